[rtl/rcve_pkg.sv]
// rcve_pkg: shared types and constants of the rc channel value encoder
// channel codes, extra telemetry keys, configuration register indexes
// no dependencies
`default_nettype none

package rcve_pkg;

  // requested channel
  typedef enum logic [2:0] {
    CH_STICK0 = 3'd0,
    CH_STICK1 = 3'd1,
    CH_STICK2 = 3'd2,
    CH_STICK3 = 3'd3,
    CH_TOGGLE = 3'd4,
    CH_RIGHT  = 3'd5,
    CH_SWITCH = 3'd6,
    CH_EXTRA  = 3'd7
  } chan_e;

  // key carried in bits 10:8 of the extra channel
  typedef enum logic [2:0] {
    KEY_ACK   = 3'd0,
    KEY_YEAR  = 3'd1,
    KEY_MONTH = 3'd2,
    KEY_DAY   = 3'd3,
    KEY_RSSI  = 3'd4,
    KEY_PPS   = 3'd5,
    KEY_BOOT  = 3'd6
  } extra_key_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_YEAR  = 2'd0,
    CFG_MONTH = 2'd1,
    CFG_DAY   = 2'd2
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned WordW    = 11;
  localparam int unsigned StickW   = 10;

  localparam logic [10:0] StickMax  = 11'd1000;
  localparam logic [10:0] BtnBonus  = 11'd100;
  localparam logic [10:0] SwStep    = 11'd100;
  localparam logic signed [11:0] Mid        = 12'sd500;
  localparam logic signed [15:0] ScaleNum   = 16'sd27;
  localparam int unsigned        ScaleShift = 5;
  localparam logic signed [11:0] Center     = 12'sd512;

  // request to the left button latch
  typedef struct packed {
    logic update;
    logic left_down;
    logic other_active;
  } btn_req_t;

  // rotation through the seven extra keys
  function automatic extra_key_e next_key(extra_key_e key);
    extra_key_e nxt;
    nxt = KEY_ACK;
    unique case (key)
      KEY_ACK:   nxt = KEY_YEAR;
      KEY_YEAR:  nxt = KEY_MONTH;
      KEY_MONTH: nxt = KEY_DAY;
      KEY_DAY:   nxt = KEY_RSSI;
      KEY_RSSI:  nxt = KEY_PPS;
      KEY_PPS:   nxt = KEY_BOOT;
      default:   nxt = KEY_ACK;
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

[rtl/rc_channel_value_encoder.sv]
// rc_channel_value_encoder: top level of the radio channel word encoder
// uses rcve_pkg and rcve_debounce
`default_nettype none

// Each input transfer requests one of eight channels and yields one 11-bit channel
// word. The block is a two-register pipeline: an input register holds the request,
// one short pass of logic (a clamp, a multiply by a constant and a shift, or the
// extra-key mux) computes the word, and an output register presents it. Throughput
// is one transfer per clock while the output is not stalled; a request passes the input
// register and then the output register before its word is valid at the output.
// The button latch and the extra-key rotation advance when a request moves
// from the input register to the output register, so they follow request order.
// The output register lets a new request enter while a finished word waits; the
// input side stalls only when both registers are full and the output is stalled.
// Configuration writes (year offset, month, day) take effect at once; the user must
// make them only while the block is idle, as the block itself does not enforce it.
module rc_channel_value_encoder #(
  parameter int unsigned HOLD_TICKS  = 10,
  parameter int unsigned ACK_REPEATS = 20
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [rcve_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rcve_pkg::CfgDataW-1:0]  cfg_data_i,
  // request channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [2:0]                     channel_index_i,
  input  wire logic [rcve_pkg::StickW-1:0]    stick_sample_i,
  input  wire logic                           left_pin_i,
  input  wire logic                           right_pin_i,
  input  wire logic                           sw1_pin_i,
  input  wire logic                           sw2_pin_i,
  input  wire logic                           user_pin_i,
  input  wire logic [7:0]                     telem_ack_i,
  input  wire logic [7:0]                     telem_rssi_i,
  input  wire logic [7:0]                     telem_pps_i,
  input  wire logic [7:0]                     boot_version_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [rcve_pkg::WordW-1:0]          channel_word_o
);

  localparam logic [7:0] AckRepeats = 8'(ACK_REPEATS);

  // registered request
  typedef struct packed {
    rcve_pkg::chan_e             chan;
    logic [rcve_pkg::StickW-1:0] stick;
    logic                        left_down;
    logic                        right_down;
    logic                        sw1_on;
    logic                        sw2_on;
    logic                        user_on;
    logic [7:0]                  ack;
    logic [7:0]                  rssi;
    logic [7:0]                  pps;
    logic [7:0]                  bootv;
  } req_t;

  // configuration registers
  logic [7:0] year_q;
  logic [3:0] month_q;
  logic [4:0] day_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= 8'd0;
      month_q <= 4'd1;
      day_q   <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (rcve_pkg::cfg_reg_e'(cfg_index_i))
        rcve_pkg::CFG_YEAR:  year_q  <= cfg_data_i;
        rcve_pkg::CFG_MONTH: month_q <= cfg_data_i[3:0];
        rcve_pkg::CFG_DAY:   day_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_q, out_valid_q;
  logic out_load, s1_fire, in_fire;
  req_t s1_q;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_fire || (s1_valid_q && !s1_fire);
      out_valid_q <= s1_fire || (out_valid_q && !out_load);
    end
  end

  // input register, pin levels turned into active flags
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.chan       <= rcve_pkg::chan_e'(channel_index_i);
      s1_q.stick      <= stick_sample_i;
      s1_q.left_down  <= ~left_pin_i;
      s1_q.right_down <= ~right_pin_i;
      s1_q.sw1_on     <= ~sw1_pin_i;
      s1_q.sw2_on     <= ~sw2_pin_i;
      s1_q.user_on    <= user_pin_i;
      s1_q.ack        <= telem_ack_i;
      s1_q.rssi       <= telem_rssi_i;
      s1_q.pps        <= telem_pps_i;
      s1_q.bootv      <= boot_version_i;
    end
  end

  // left button latch
  rcve_pkg::btn_req_t btn_req;
  logic               latched;

  assign btn_req.update       = s1_fire && (s1_q.chan == rcve_pkg::CH_TOGGLE);
  assign btn_req.left_down    = s1_q.left_down;
  assign btn_req.other_active = s1_q.sw1_on | s1_q.sw2_on | s1_q.user_on | s1_q.right_down;

  rcve_debounce #(
    .HOLD_TICKS (HOLD_TICKS)
  ) u_debounce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .btn_i     (btn_req),
    .latched_o (latched)
  );

  // analog-style value before scaling, 0..1100
  logic [10:0]        stick_clamp;
  logic [10:0]        raw_val;
  logic signed [11:0] centered;
  logic signed [15:0] prod;
  logic signed [15:0] prod_adj;
  logic signed [15:0] quot;
  logic signed [11:0] shifted;
  logic [10:0]        scaled_word;

  assign stick_clamp = ({1'b0, s1_q.stick} > rcve_pkg::StickMax) ? rcve_pkg::StickMax
                                                                 : {1'b0, s1_q.stick};

  always_comb begin
    raw_val = '0;
    unique case (s1_q.chan)
      rcve_pkg::CH_STICK0: raw_val = stick_clamp;
      rcve_pkg::CH_STICK1,
      rcve_pkg::CH_STICK2,
      rcve_pkg::CH_STICK3: raw_val = rcve_pkg::StickMax - stick_clamp;
      rcve_pkg::CH_TOGGLE: raw_val = (latched ? rcve_pkg::StickMax : 11'd0)
                                     + (s1_q.left_down ? rcve_pkg::BtnBonus : 11'd0);
      rcve_pkg::CH_RIGHT:  raw_val = s1_q.right_down ? rcve_pkg::StickMax : 11'd0;
      rcve_pkg::CH_SWITCH: raw_val = 11'({s1_q.user_on, s1_q.sw2_on, s1_q.sw1_on}
                                         * rcve_pkg::SwStep);
      default:             raw_val = '0;
    endcase
  end

  // ((v - 500) * 27 / 32 + 512) * 2, division truncated toward zero
  assign centered    = $signed({1'b0, raw_val}) - rcve_pkg::Mid;
  assign prod        = 16'(centered) * rcve_pkg::ScaleNum;
  assign prod_adj    = prod + (prod[15] ? 16'sd31 : 16'sd0);
  assign quot        = prod_adj >>> rcve_pkg::ScaleShift;
  assign shifted     = 12'(quot) + rcve_pkg::Center;
  assign scaled_word = {shifted[9:0], 1'b0};

  // extra channel: ack repeats and key rotation
  rcve_pkg::extra_key_e key_q, key_d, key_nxt;
  logic [7:0]           prev_ack_q, prev_ack_d;
  logic [7:0]           ack_sends_q, ack_sends_d;
  logic                 ack_changed;
  logic                 send_ack;
  logic [7:0]           key_data;
  logic [10:0]          extra_word;

  assign key_nxt     = rcve_pkg::next_key(key_q);
  assign ack_changed = s1_q.ack != prev_ack_q;
  assign send_ack    = (key_nxt == rcve_pkg::KEY_ACK) || ack_changed
                       || (ack_sends_q < AckRepeats);

  always_comb begin
    key_data = s1_q.bootv;
    unique case (key_nxt)
      rcve_pkg::KEY_YEAR:  key_data = year_q;
      rcve_pkg::KEY_MONTH: key_data = {4'd0, month_q};
      rcve_pkg::KEY_DAY:   key_data = {3'd0, day_q};
      rcve_pkg::KEY_RSSI:  key_data = s1_q.rssi;
      rcve_pkg::KEY_PPS:   key_data = s1_q.pps;
      default:             key_data = s1_q.bootv;
    endcase
  end

  assign extra_word = send_ack ? {3'd0, s1_q.ack} : {key_nxt, key_data};

  always_comb begin
    key_d       = key_q;
    prev_ack_d  = prev_ack_q;
    ack_sends_d = ack_sends_q;
    if (s1_fire && (s1_q.chan == rcve_pkg::CH_EXTRA)) begin
      key_d = key_nxt;
      if (send_ack) begin
        // a new ack restarts the repeat count
        prev_ack_d  = s1_q.ack;
        ack_sends_d = (ack_changed ? 8'd0 : ack_sends_q) + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= rcve_pkg::KEY_ACK;
      prev_ack_q  <= '0;
      ack_sends_q <= '0;
    end else begin
      key_q       <= key_d;
      prev_ack_q  <= prev_ack_d;
      ack_sends_q <= ack_sends_d;
    end
  end

  // output register
  logic [10:0] word_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      word_q <= (s1_q.chan == rcve_pkg::CH_EXTRA) ? extra_word : scaled_word;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign channel_word_o = word_q;

  // input side stalls only when both registers are full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");

  // a new word appears only from a held request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !s1_valid_q) |=> !out_valid_q)
    else $error("output word without a request");

  // extra channel state moves only on a transfer of an extra request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_fire && (s1_q.chan == rcve_pkg::CH_EXTRA))
      |=> ($stable(key_q) && $stable(ack_sends_q) && $stable(prev_ack_q)))
    else $error("extra channel state changed without a request");

  // a changed ack is counted as its first send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_q.chan == rcve_pkg::CH_EXTRA) && ack_changed)
      |=> (ack_sends_q == 8'd1))
    else $error("repeat count not restarted on a new ack");

  // rotation wraps from the last key to the ack slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_q.chan == rcve_pkg::CH_EXTRA) && (key_q == rcve_pkg::KEY_BOOT))
      |=> (key_q == rcve_pkg::KEY_ACK))
    else $error("extra key rotation did not wrap");

endmodule

`default_nettype wire

[rtl/rcve_debounce.sv]
// rcve_debounce: hold counter and toggle latch of the left button
// uses rcve_pkg for the request struct
`default_nettype none

module rcve_debounce #(
  parameter int unsigned HOLD_TICKS = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rcve_pkg::btn_req_t btn_i,
  output logic                   latched_o
);

  localparam logic [3:0] HoldTicks = 4'(HOLD_TICKS);
  localparam logic [3:0] HoldMax   = 4'(HOLD_TICKS + 1);

  logic [3:0] press_count_q, press_count_d;
  logic       toggle_q, toggle_d;
  logic       combo_q, combo_d;
  logic [3:0] count_inc;
  logic       combo_set;

  always_comb begin
    press_count_d = press_count_q;
    toggle_d      = toggle_q;
    combo_d       = combo_q;
    count_inc     = (press_count_q < HoldMax) ? press_count_q + 4'd1 : press_count_q;
    combo_set     = combo_q | btn_i.other_active;
    if (btn_i.update) begin
      if (!btn_i.left_down) begin
        // release: toggle after a clean long enough press
        if (press_count_q >= HoldTicks && !combo_q) begin
          toggle_d = ~toggle_q;
        end
        press_count_d = '0;
        combo_d       = 1'b0;
      end else begin
        combo_d       = combo_set;
        press_count_d = combo_set ? 4'd0 : count_inc;
      end
    end
  end

  assign latched_o = toggle_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_count_q <= '0;
      toggle_q      <= 1'b0;
      combo_q       <= 1'b0;
    end else begin
      press_count_q <= press_count_d;
      toggle_q      <= toggle_d;
      combo_q       <= combo_d;
    end
  end

  // a combination press never counts up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    combo_q |-> press_count_q == 4'd0)
    else $error("press counter running during a button combination");

  // the latch toggles only on a request with the button released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (toggle_q != toggle_d) |-> (btn_i.update && !btn_i.left_down))
    else $error("toggle latch changed without a release");

endmodule

`default_nettype wire
